[rtl/vertex_affine_transform_core_defines.svh]
// ---------------------------------------------------------------------------
// Vertex affine transform assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef VERTEX_AFFINE_TRANSFORM_CORE_DEFINES_SVH
`define VERTEX_AFFINE_TRANSFORM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define VAT_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vertex transform check failed");
`define VAT_ASSERT_NEVER(name, clk, rstn, expr) \
  `VAT_ASSERT(name, clk, rstn, !(expr))
`else
`define VAT_ASSERT(name, clk, rstn, prop)
`define VAT_ASSERT_NEVER(name, clk, rstn, expr)
`endif

`endif

[rtl/vat_pkg.sv]
// ---------------------------------------------------------------------------
// Vertex affine transform package
// Types, operation codes and CORDIC constants shared by the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package vat_pkg;

  typedef enum logic [2:0] {
    FN_TRANSLATE = 3'd0,
    FN_ROT_X     = 3'd1,
    FN_ROT_Y     = 3'd2,
    FN_ROT_Z     = 3'd3,
    FN_CEN_X     = 3'd4,
    FN_CEN_Y     = 3'd5,
    FN_CEN_Z     = 3'd6,
    FN_MATRIX    = 3'd7
  } func_e;

  typedef enum logic [3:0] {
    CFG_ANGLE   = 4'd0,
    CFG_DEGREES = 4'd1,
    CFG_CX      = 4'd2,
    CFG_CY      = 4'd3,
    CFG_CZ      = 4'd4,
    CFG_ROW0    = 4'd5,
    CFG_ROW1    = 4'd6,
    CFG_ROW2    = 4'd7
  } cfg_e;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 63;
  localparam int unsigned CoefW    = 21;
  localparam int unsigned CordW    = 34;

  // Angle to turn-phase scale factors (2^32 per full turn).
  localparam logic [29:0] RAD_SCALE = 30'd683565276;
  localparam logic [29:0] DEG_SCALE = 30'd11930465;
  localparam logic signed [CordW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CordW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CordW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [31:0]      ONE_Q30      = 32'sd1073741824;

  localparam logic [31:0] TURN_ATAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  function automatic sat_t sat32(input logic signed [36:0] v);
    sat_t r;
    if (v > 37'sd2147483647) begin
      r.val = 32'sh7FFFFFFF;
      r.hit = 1'b1;
    end else if (v < -37'sd2147483648) begin
      r.val = 32'sh80000000;
      r.hit = 1'b1;
    end else begin
      r.val = v[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/vat_in_if.sv]
// ---------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel carrying one vertex and its operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface vat_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;

  modport source (output valid, func, pos_x, pos_y, pos_z, offset_x, offset_y,
                  offset_z, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, offset_x, offset_y,
                offset_z, output ready);
endinterface

`default_nettype wire

[rtl/vat_out_if.sv]
// ---------------------------------------------------------------------------
// Vertex result channel
// Valid/ready channel carrying one transformed vertex.
// ---------------------------------------------------------------------------
`default_nettype none

interface vat_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

[rtl/vat_cordic_stage.sv]
// ---------------------------------------------------------------------------
// CORDIC rotation stage
// One registered micro-rotation with a fixed shift and arctangent.
// ---------------------------------------------------------------------------
`default_nettype none

module vat_cordic_stage import vat_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [CordW-1:0] x_i,
  input  wire logic signed [CordW-1:0] y_i,
  input  wire logic signed [CordW-1:0] z_i,
  input  wire logic                    flip_i,
  output logic signed [CordW-1:0]      x_o,
  output logic signed [CordW-1:0]      y_o,
  output logic signed [CordW-1:0]      z_o,
  output logic                         flip_o
);

  localparam logic signed [CordW-1:0] ATAN = $signed({2'b00, TURN_ATAN[STEP]});

  logic signed [CordW-1:0] dx, dy;
  logic signed [CordW-1:0] x_d, y_d, z_d;
  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic                    flip_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!z_i[CordW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      flip_q <= flip_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

`default_nettype wire

[rtl/vat_sincos.sv]
// ---------------------------------------------------------------------------
// Pipelined sine and cosine
// Angle scaling, quadrant fold, CORDIC stages and final sign and clamp.
// ---------------------------------------------------------------------------
`default_nettype none

module vat_sincos import vat_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  wire logic                    clk_i,
  input  wire logic [CORDIC_STEPS+2:0] en_i,
  input  wire logic signed [31:0]      angle_i,
  input  wire logic                    deg_i,
  output logic signed [31:0]           cos_o,
  output logic signed [31:0]           sin_o
);

  logic [29:0]              scale;
  logic signed [63:0]       prod_d, prod_q;
  logic [47:0]              rnd;
  logic signed [CordW-1:0]  z_fold;
  logic signed [CordW-1:0]  z_init;
  logic                     flip_init;
  logic signed [CordW-1:0]  x_s [CORDIC_STEPS+1];
  logic signed [CordW-1:0]  y_s [CORDIC_STEPS+1];
  logic signed [CordW-1:0]  z_s [CORDIC_STEPS+1];
  logic                     f_s [CORDIC_STEPS+1];
  logic signed [CordW-1:0]  xf, yf;
  logic signed [CordW-1:0]  xc, yc;
  logic signed [31:0]       cos_q, sin_q;

  assign scale  = deg_i ? DEG_SCALE : RAD_SCALE;
  assign prod_d = angle_i * $signed({1'b0, scale});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
  end

  // Phase in 2^-32 turn; fold it into [-quarter, +quarter] turn.
  assign rnd    = prod_q[47:0] + 48'h8000;
  assign z_fold = CordW'($signed(rnd[47:16]));

  always_comb begin
    z_init    = z_fold;
    flip_init = 1'b0;
    if (z_fold > QUARTER_TURN) begin
      z_init    = z_fold - HALF_TURN;
      flip_init = 1'b1;
    end else if (z_fold < -QUARTER_TURN) begin
      z_init    = z_fold + HALF_TURN;
      flip_init = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_s[0] <= CORDIC_GAIN;
      y_s[0] <= '0;
      z_s[0] <= z_init;
      f_s[0] <= flip_init;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    vat_cordic_stage #(.STEP(i)) u_stage (
      .clk_i  (clk_i),
      .en_i   (en_i[i+2]),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .flip_i (f_s[i]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1]),
      .flip_o (f_s[i+1])
    );
  end

  assign xf = f_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
  assign yf = f_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];

  always_comb begin
    xc = xf;
    yc = yf;
    if (xf > QUARTER_TURN) xc = QUARTER_TURN;
    if (xf < -QUARTER_TURN) xc = -QUARTER_TURN;
    if (yf > QUARTER_TURN) yc = QUARTER_TURN;
    if (yf < -QUARTER_TURN) yc = -QUARTER_TURN;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[CORDIC_STEPS+2]) begin
      cos_q <= xc[31:0];
      sin_q <= yc[31:0];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

[rtl/vat_xform.sv]
// ---------------------------------------------------------------------------
// Vertex transform datapath
// Center offset and axis select, products, rounding and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module vat_xform import vat_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic [2:0]            en_i,
  input  wire item_t                 item_i,
  input  wire logic signed [31:0]    cos_i,
  input  wire logic signed [31:0]    sin_i,
  input  wire logic signed [31:0]    cx_i,
  input  wire logic signed [31:0]    cy_i,
  input  wire logic signed [31:0]    cz_i,
  input  wire logic [CfgDataW-1:0]   row0_i,
  input  wire logic [CfgDataW-1:0]   row1_i,
  input  wire logic [CfgDataW-1:0]   row2_i,
  output result_t                    res_o
);

  function automatic logic is_centered(input logic [2:0] f);
    return (f == FN_CEN_X) || (f == FN_CEN_Y) || (f == FN_CEN_Z);
  endfunction

  // Stage A: differences to the center, translate sums, rotation pair select.
  logic               cen_a;
  logic signed [32:0] ecx, ecy, ecz;
  logic signed [32:0] dx_d, dy_d, dz_d, a_d, b_d;
  logic [2:0]         func_a_q;
  logic signed [32:0] dx_a_q, dy_a_q, dz_a_q, tx_a_q, ty_a_q, tz_a_q, a_a_q, b_a_q;
  logic signed [31:0] px_a_q, py_a_q, pz_a_q;

  assign cen_a = is_centered(item_i.func);
  assign ecx   = cen_a ? 33'(cx_i) : '0;
  assign ecy   = cen_a ? 33'(cy_i) : '0;
  assign ecz   = cen_a ? 33'(cz_i) : '0;
  assign dx_d  = 33'(item_i.pos_x) - ecx;
  assign dy_d  = 33'(item_i.pos_y) - ecy;
  assign dz_d  = 33'(item_i.pos_z) - ecz;

  always_comb begin
    case (item_i.func)
      FN_ROT_X, FN_CEN_X: begin
        a_d = dy_d;
        b_d = dz_d;
      end
      FN_ROT_Y, FN_CEN_Y: begin
        a_d = dx_d;
        b_d = dz_d;
      end
      default: begin
        a_d = dx_d;
        b_d = dy_d;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      func_a_q <= item_i.func;
      dx_a_q   <= dx_d;
      dy_a_q   <= dy_d;
      dz_a_q   <= dz_d;
      tx_a_q   <= 33'(item_i.pos_x) + 33'(item_i.offset_x);
      ty_a_q   <= 33'(item_i.pos_y) + 33'(item_i.offset_y);
      tz_a_q   <= 33'(item_i.pos_z) + 33'(item_i.offset_z);
      px_a_q   <= item_i.pos_x;
      py_a_q   <= item_i.pos_y;
      pz_a_q   <= item_i.pos_z;
      a_a_q    <= a_d;
      b_a_q    <= b_d;
    end
  end

  // Stage B: rotation and matrix products.
  logic signed [CoefW-1:0] m [3][3];
  logic [CfgDataW-1:0]     rows [3];
  logic signed [31:0]      pv [3];
  logic [2:0]              func_b_q;
  logic signed [32:0]      dx_b_q, dy_b_q, dz_b_q, tx_b_q, ty_b_q, tz_b_q;
  logic signed [63:0]      pac_q, pbs_q, pbc_q, pas_q;
  logic signed [52:0]      mp_q [3][3];

  assign rows[0] = row0_i;
  assign rows[1] = row1_i;
  assign rows[2] = row2_i;
  assign pv[0]   = px_a_q;
  assign pv[1]   = py_a_q;
  assign pv[2]   = pz_a_q;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign m[r][c] = $signed(rows[r][CoefW*c +: CoefW]);
      always_ff @(posedge clk_i) begin
        if (en_i[1]) begin
          mp_q[r][c] <= m[r][c] * pv[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      func_b_q <= func_a_q;
      dx_b_q   <= dx_a_q;
      dy_b_q   <= dy_a_q;
      dz_b_q   <= dz_a_q;
      tx_b_q   <= tx_a_q;
      ty_b_q   <= ty_a_q;
      tz_b_q   <= tz_a_q;
      pac_q    <= a_a_q * cos_i;
      pbs_q    <= b_a_q * sin_i;
      pbc_q    <= b_a_q * cos_i;
      pas_q    <= a_a_q * sin_i;
    end
  end

  // Stage C: round, add the center back, select and saturate.
  logic signed [65:0] ra, rb;
  logic signed [35:0] na, nb, nx, ny, nz;
  logic signed [54:0] ms [3];
  logic signed [36:0] vx, vy, vz;
  logic               cen_b;
  logic signed [36:0] ocx, ocy, ocz;
  sat_t               sx, sy, sz;
  result_t            res_q;

  assign ra = 66'(pac_q) + 66'(pbs_q) + 66'sd536870912;
  assign rb = 66'(pbc_q) - 66'(pas_q) + 66'sd536870912;
  assign na = ra[65:30];
  assign nb = rb[65:30];

  for (genvar r = 0; r < 3; r++) begin : g_msum
    logic signed [54:0] acc;
    assign acc   = 55'(mp_q[r][0]) + 55'(mp_q[r][1]) + 55'(mp_q[r][2]) + 55'sd131072;
    assign ms[r] = acc;
  end

  assign cen_b = is_centered(func_b_q);
  assign ocx   = cen_b ? 37'(cx_i) : '0;
  assign ocy   = cen_b ? 37'(cy_i) : '0;
  assign ocz   = cen_b ? 37'(cz_i) : '0;

  always_comb begin
    nx = 36'(dx_b_q);
    ny = 36'(dy_b_q);
    nz = 36'(dz_b_q);
    case (func_b_q)
      FN_ROT_X, FN_CEN_X: begin
        ny = na;
        nz = nb;
      end
      FN_ROT_Y, FN_CEN_Y: begin
        nx = na;
        nz = nb;
      end
      default: begin
        nx = na;
        ny = nb;
      end
    endcase
  end

  always_comb begin
    case (func_b_q)
      FN_TRANSLATE: begin
        vx = 37'(tx_b_q);
        vy = 37'(ty_b_q);
        vz = 37'(tz_b_q);
      end
      FN_MATRIX: begin
        vx = ms[0][54:18];
        vy = ms[1][54:18];
        vz = ms[2][54:18];
      end
      default: begin
        vx = 37'(nx) + ocx;
        vy = 37'(ny) + ocy;
        vz = 37'(nz) + ocz;
      end
    endcase
  end

  assign sx = sat32(vx);
  assign sy = sat32(vy);
  assign sz = sat32(vz);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      res_q.out_x     <= sx.val;
      res_q.out_y     <= sy.val;
      res_q.out_z     <= sz.val;
      res_q.saturated <= sx.hit | sy.hit | sz.hit;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/vertex_affine_transform_core.sv]
// ---------------------------------------------------------------------------
// Vertex affine transform core
// Translates, rotates or matrix-multiplies one Q16.16 vertex per beat.
// ---------------------------------------------------------------------------
// The core accepts one vertex beat every clock while the output is not stalled
// and returns one result beat per vertex, in order. The pipeline depth is set
// by the sine/cosine pipeline, one CORDIC stage per iteration, which each vertex
// walks alongside its coordinates. Each stage advances whenever the stage after
// it is empty or moving, so bubbles close up under back-pressure. Configuration
// must be written only while no vertex is in flight; sine and cosine are taken
// from the current angle registers as the vertex passes through.
`default_nettype none

`include "vertex_affine_transform_core_defines.svh"

module vertex_affine_transform_core import vat_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  vat_in_if.sink                   in_i,
  vat_out_if.source                out_o
);

  localparam int unsigned NumStages = CORDIC_STEPS + 5;
  localparam int unsigned XfStage   = CORDIC_STEPS + 2;

  // Configuration registers.
  logic signed [31:0]    angle_q, cx_q, cy_q, cz_q;
  logic                  deg_q;
  logic [CfgDataW-1:0]   row0_q, row1_q, row2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      deg_q   <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      row0_q  <= '0;
      row1_q  <= '0;
      row2_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE:   angle_q <= cfg_wdata_i[31:0];
        CFG_DEGREES: deg_q   <= cfg_wdata_i[0];
        CFG_CX:      cx_q    <= cfg_wdata_i[31:0];
        CFG_CY:      cy_q    <= cfg_wdata_i[31:0];
        CFG_CZ:      cz_q    <= cfg_wdata_i[31:0];
        CFG_ROW0:    row0_q  <= cfg_wdata_i;
        CFG_ROW1:    row1_q  <= cfg_wdata_i;
        CFG_ROW2:    row2_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance.
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   adv;

  assign adv[NumStages] = out_o.ready;
  for (genvar k = 0; k < NumStages; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_i.ready = adv[0];

  // Vertex payload travels beside the sine/cosine pipeline.
  item_t item_in;
  item_t item_q [XfStage];

  assign item_in.func     = in_i.func;
  assign item_in.pos_x    = in_i.pos_x;
  assign item_in.pos_y    = in_i.pos_y;
  assign item_in.pos_z    = in_i.pos_z;
  assign item_in.offset_x = in_i.offset_x;
  assign item_in.offset_y = in_i.offset_y;
  assign item_in.offset_z = in_i.offset_z;

  always_ff @(posedge clk_i) begin
    if (adv[0]) item_q[0] <= item_in;
    for (int k = 1; k < XfStage; k++) begin
      if (adv[k]) item_q[k] <= item_q[k-1];
    end
  end

  logic signed [31:0] cos_w, sin_w;
  result_t            res_w;

  vat_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
    .clk_i   (clk_i),
    .en_i    (adv[XfStage:0]),
    .angle_i (angle_q),
    .deg_i   (deg_q),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  vat_xform u_xform (
    .clk_i  (clk_i),
    .en_i   (adv[NumStages-1:XfStage]),
    .item_i (item_q[XfStage-1]),
    .cos_i  (cos_w),
    .sin_i  (sin_w),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .cz_i   (cz_q),
    .row0_i (row0_q),
    .row1_i (row1_q),
    .row2_i (row2_q),
    .res_o  (res_w)
  );

  assign out_o.valid     = valid_q[NumStages-1];
  assign out_o.out_x     = res_w.out_x;
  assign out_o.out_y     = res_w.out_y;
  assign out_o.out_z     = res_w.out_z;
  assign out_o.saturated = res_w.saturated;

  logic out_at_rail;
  logic trig_out_of_range;

  assign out_at_rail = (out_o.out_x == 32'sh7FFFFFFF) || (out_o.out_x == 32'sh80000000) ||
                       (out_o.out_y == 32'sh7FFFFFFF) || (out_o.out_y == 32'sh80000000) ||
                       (out_o.out_z == 32'sh7FFFFFFF) || (out_o.out_z == 32'sh80000000);
  assign trig_out_of_range = (cos_w > ONE_Q30) || (cos_w < -ONE_Q30) ||
                             (sin_w > ONE_Q30) || (sin_w < -ONE_Q30);

  // Input back-pressure only when every stage holds a vertex.
  `VAT_ASSERT(a_full_when_blocked, clk_i, rst_ni, !in_i.ready |-> &valid_q)
  // A clipped result has at least one coordinate at a rail.
  `VAT_ASSERT(a_sat_at_rail, clk_i, rst_ni, (out_o.valid && out_o.saturated) |-> out_at_rail)
  // Sine and cosine entering the products lie within plus or minus one.
  `VAT_ASSERT_NEVER(a_trig_range, clk_i, rst_ni, valid_q[XfStage] && trig_out_of_range)

endmodule

`default_nettype wire

[tb/vat_transform_checker.sv]
// ---------------------------------------------------------------------------
// Vertex transform checker
// Watches the vertex and result channels, predicts each transformed vertex
// and compares it field by field with the beats the core returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module vat_transform_checker import vat_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  vat_in_if                        in_mon,
  vat_out_if                       out_mon,
  output int                       mismatch_o,
  output int                       pending_o,
  output int                       checked_o
);

  logic [31:0] angle_q;
  logic        in_degrees;
  logic [31:0] center_q [3];
  logic [62:0] matrix_row [3];

  result_t expected_vertices [$];

  // Sine and cosine in Q2.30 for the current angle.
  task automatic angle_trig(output longint cos_q, output longint sin_q);
    longint scale, phase, xa, ya, dx, dy;
    logic   flip;
    scale = in_degrees ? 64'd11930465 : 64'd683565276;
    phase = (longint'($signed(angle_q)) * scale + 64'd32768) >> 16;
    phase = phase & 64'hFFFF_FFFF;
    if (phase >= 64'sd2147483648) phase = phase - 64'sd4294967296;
    flip = 1'b0;
    if (phase > 64'sd1073741824) begin
      phase = phase - 64'sd2147483648;
      flip = 1'b1;
    end else if (phase < -64'sd1073741824) begin
      phase = phase + 64'sd2147483648;
      flip = 1'b1;
    end
    xa = 64'sd652032874;
    ya = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (phase >= 0) begin
        xa = xa - dx;
        ya = ya + dy;
        phase = phase - longint'(TURN_ATAN[i]);
      end else begin
        xa = xa + dx;
        ya = ya - dy;
        phase = phase + longint'(TURN_ATAN[i]);
      end
    end
    if (flip) begin
      xa = -xa;
      ya = -ya;
    end
    if (xa > 64'sd1073741824) xa = 64'sd1073741824;
    if (xa < -64'sd1073741824) xa = -64'sd1073741824;
    if (ya > 64'sd1073741824) ya = 64'sd1073741824;
    if (ya < -64'sd1073741824) ya = -64'sd1073741824;
    cos_q = xa;
    sin_q = ya;
  endtask

  task automatic turn_coords(inout longint a, inout longint b, input longint c,
                             input longint s);
    longint na, nb;
    na = (a * c + b * s + (64'sd1 <<< 29)) >>> 30;
    nb = (b * c - a * s + (64'sd1 <<< 29)) >>> 30;
    a = na;
    b = nb;
  endtask

  function automatic longint row_dot(logic [62:0] row, longint x, longint y,
                                     longint z);
    longint m0, m1, m2;
    m0 = longint'($signed(row[20:0]));
    m1 = longint'($signed(row[41:21]));
    m2 = longint'($signed(row[62:42]));
    return (m0 * x + m1 * y + m2 * z + (64'sd1 <<< 17)) >>> 18;
  endfunction

  task automatic clip_coord(input longint v, output logic [31:0] q, inout logic hit);
    if (v > 64'sd2147483647) begin
      q = 32'h7FFF_FFFF;
      hit = 1'b1;
    end else if (v < -64'sd2147483648) begin
      q = 32'h8000_0000;
      hit = 1'b1;
    end else begin
      q = v[31:0];
    end
  endtask

  task automatic transform_vertex(input item_t v, output result_t r);
    longint x, y, z, cx, cy, cz, c, s, nx, ny, nz;
    logic   hit;
    func_e  fn;
    fn = func_e'(v.func);
    x = v.pos_x;
    y = v.pos_y;
    z = v.pos_z;
    cx = 0;
    cy = 0;
    cz = 0;
    hit = 1'b0;
    if (fn == FN_TRANSLATE) begin
      x = x + longint'(v.offset_x);
      y = y + longint'(v.offset_y);
      z = z + longint'(v.offset_z);
    end else if (fn == FN_MATRIX) begin
      nx = row_dot(matrix_row[0], x, y, z);
      ny = row_dot(matrix_row[1], x, y, z);
      nz = row_dot(matrix_row[2], x, y, z);
      x = nx;
      y = ny;
      z = nz;
    end else begin
      if (fn inside {FN_CEN_X, FN_CEN_Y, FN_CEN_Z}) begin
        cx = longint'($signed(center_q[0]));
        cy = longint'($signed(center_q[1]));
        cz = longint'($signed(center_q[2]));
      end
      x = x - cx;
      y = y - cy;
      z = z - cz;
      angle_trig(c, s);
      case (fn)
        FN_ROT_X, FN_CEN_X: turn_coords(y, z, c, s);
        FN_ROT_Y, FN_CEN_Y: turn_coords(x, z, c, s);
        default:            turn_coords(x, y, c, s);
      endcase
      x = x + cx;
      y = y + cy;
      z = z + cz;
    end
    clip_coord(x, r.out_x, hit);
    clip_coord(y, r.out_y, hit);
    clip_coord(z, r.out_z, hit);
    r.saturated = hit;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   vin;
    result_t want;
    if (!rst_ni) begin
      angle_q <= '0;
      in_degrees <= 1'b0;
      center_q <= '{default: '0};
      matrix_row <= '{default: '0};
      expected_vertices.delete();
      mismatch_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_ANGLE:   angle_q <= cfg_wdata_i[31:0];
          CFG_DEGREES: in_degrees <= cfg_wdata_i[0];
          CFG_CX:      center_q[0] <= cfg_wdata_i[31:0];
          CFG_CY:      center_q[1] <= cfg_wdata_i[31:0];
          CFG_CZ:      center_q[2] <= cfg_wdata_i[31:0];
          CFG_ROW0:    matrix_row[0] <= cfg_wdata_i;
          CFG_ROW1:    matrix_row[1] <= cfg_wdata_i;
          CFG_ROW2:    matrix_row[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        checked_o <= checked_o + 1;
        if (expected_vertices.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h %h %h %b", $time,
                   out_mon.out_x, out_mon.out_y, out_mon.out_z, out_mon.saturated);
          mismatch_o <= mismatch_o + 1;
        end else begin
          want = expected_vertices.pop_front();
          if (want.out_x !== out_mon.out_x || want.out_y !== out_mon.out_y ||
              want.out_z !== out_mon.out_z || want.saturated !== out_mon.saturated) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h sat=%b", $time,
                     want.out_x, want.out_y, want.out_z, want.saturated);
            $display("%0t:          actual   x=%h y=%h z=%h sat=%b", $time,
                     out_mon.out_x, out_mon.out_y, out_mon.out_z, out_mon.saturated);
            mismatch_o <= mismatch_o + 1;
          end
        end
      end
      // A vertex beat is predicted after any pop in this edge so order holds.
      if (in_mon.valid && in_mon.ready) begin
        vin.func = in_mon.func;
        vin.pos_x = in_mon.pos_x;
        vin.pos_y = in_mon.pos_y;
        vin.pos_z = in_mon.pos_z;
        vin.offset_x = in_mon.offset_x;
        vin.offset_y = in_mon.offset_y;
        vin.offset_z = in_mon.offset_z;
        transform_vertex(vin, want);
        expected_vertices.push_back(want);
      end
    end
  end

  assign pending_o = expected_vertices.size();

endmodule

[tb/vertex_affine_transform_core_tb.sv]
// ---------------------------------------------------------------------------
// Vertex affine transform core testbench
// Drives vertices under several angle, center and matrix settings with random
// gaps and back-pressure; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module vertex_affine_transform_core_tb import vat_pkg::*;;

  localparam int unsigned Steps = 18;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  mismatches, pending, checked;
  int                  sent_vertices;
  logic                long_hold_go, long_hold_done;

  vat_in_if  in_ch ();
  vat_out_if out_ch ();

  vertex_affine_transform_core #(.CORDIC_STEPS(Steps)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  vat_transform_checker #(.CORDIC_STEPS(Steps)) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatch_o (mismatches),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Result-side back-pressure: random stalls, stretches of none, one long hold.
  initial begin
    int stall_mode;
    out_ch.ready = 1'b0;
    long_hold_done = 1'b0;
    stall_mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else begin
        if ($urandom_range(63) == 0) stall_mode = $urandom_range(2);
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(3) != 0);
          default: begin
            out_ch.ready <= 1'b0;
            repeat (gap_length() + 1) @(posedge clk_i);
            out_ch.ready <= 1'b1;
          end
        endcase
      end
    end
  end

  task automatic write_reg(input cfg_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (Steps + 10) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] angle, input logic deg,
                               input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input logic [62:0] r0,
                               input logic [62:0] r1, input logic [62:0] r2);
    write_reg(CFG_ANGLE, {31'd0, angle});
    write_reg(CFG_DEGREES, {62'd0, deg});
    write_reg(CFG_CX, {31'd0, cx});
    write_reg(CFG_CY, {31'd0, cy});
    write_reg(CFG_CZ, {31'd0, cz});
    write_reg(CFG_ROW0, r0);
    write_reg(CFG_ROW1, r1);
    write_reg(CFG_ROW2, r2);
  endtask

  // Offers one vertex and holds it until the core takes the beat; the valid
  // stays high when the next vertex follows without a gap.
  task automatic send_vertex(input func_e fn, input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] ox,
                             input logic [31:0] oy, input logic [31:0] oz,
                             input int gap);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.offset_x <= ox;
    in_ch.offset_y <= oy;
    in_ch.offset_z <= oz;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_vertices++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      4:       return {{8{1'b0}}, 24'($urandom)} ^ {32{$urandom_range(1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [62:0] pick_row(input int col);
    logic [20:0] coef [3];
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(5))
        0:       coef[j] = 21'h0FFFFF;
        1:       coef[j] = 21'h100000;
        2:       coef[j] = (j == col) ? 21'h040000 : 21'h0;
        default: coef[j] = 21'($urandom);
      endcase
    end
    return {coef[2], coef[1], coef[0]};
  endfunction

  task automatic random_vertices(input int count);
    for (int n = 0; n < count; n++) begin
      send_vertex(func_e'($urandom_range(7)), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord(), gap_length());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_TRANSLATE;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.offset_x = '0;
    in_ch.offset_y = '0;
    in_ch.offset_z = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    long_hold_go = 1'b0;
    sent_vertices = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ninety degrees about a center, identity matrix: directed extremes.
    load_settings(32'd90 << 16, 1'b1, 32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFF,
                  63'h0000_0000_0004_0000, 63'd1 << 39, 63'd1 << 60);
    send_vertex(FN_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                32'd1, 32'hFFFF_FFFF, 32'd0, 0);
    send_vertex(FN_TRANSLATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0);
    for (int f = 1; f < 8; f++) begin
      send_vertex(func_e'(f), 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'd0, 32'd0, 32'd0, 0);
      send_vertex(func_e'(f), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'd0, 32'd0, 32'd0, 1);
    end
    send_vertex(FN_CEN_Z, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'd0, 32'd0, 32'd0, 0);
    send_vertex(FN_MATRIX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'd0, 32'd0, 32'd0, 0);
    random_vertices(80);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Keep offering while the result side holds off, so the pipe backs up.
    load_settings(32'h7FFF_FFFF, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  {21'h0FFFFF, 21'h100000, 21'h0FFFFF}, {21'h100000, 21'h0FFFFF,
                  21'h100000}, pick_row(2));
    long_hold_go = 1'b1;
    random_vertices(90);
    in_ch.valid <= 1'b0;
    wait_drained();

    load_settings(32'h8000_0000, 1'b1, $urandom, $urandom, $urandom,
                  pick_row(0), pick_row(1), pick_row(2));
    random_vertices(90);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Half a turn in degrees, then random angles in either unit.
    load_settings(32'd180 << 16, 1'b1, pick_coord(), pick_coord(), pick_coord(),
                  pick_row(0), pick_row(1), pick_row(2));
    random_vertices(90);
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      load_settings($urandom, $urandom_range(1), pick_coord(), pick_coord(),
                    pick_coord(), pick_row(0), pick_row(1), pick_row(2));
      random_vertices(90);
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    $display("Covered %0d vertices over eight register settings, %0d results checked,",
             sent_vertices, checked);
    $display("including a long result-side hold and random gaps on both channels.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
